[hdl/rphc_pkg.sv]
// Shared types and constants for the reflow profile heater controller.
// No dependencies; used by every module under hdl/ except rphc_div.
package rphc_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int TIME_W      = 32;   // millisecond times
    localparam int TEMP_W      = 14;   // signed Q10.4 temperature
    localparam int PTEMP_W     = 13;   // unsigned Q9.4 profile temperature
    localparam int BAND_W      = 11;
    localparam int USED_W      = 5;
    localparam int PIDX_W      = 4;
    localparam int PHASE_OUT_W = 4;
    localparam int CNT_W       = 8;    // holds point counts up to 64 plus one
    localparam int OP_W        = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 24;

    // interpolation math: 14b signed temp delta times 33b signed time delta
    localparam int DIFF_W = TIME_W + 1;
    localparam int PROD_W = 47;
    localparam int QMAG_W = 45;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -14'sd800;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 14'sd8000;
    localparam logic [PTEMP_W-1:0]       FIXED_MAX = 13'd8000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_USED  = 3'd4;

    localparam logic [TIME_W-1:0] RESET_TIMEOUT = 32'd60000;
    localparam logic [BAND_W-1:0] RESET_BAND    = 11'd80;
    localparam logic [USED_W-1:0] RESET_USED    = 5'd2;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic {
        RD_NEXT = 1'b0,   // curve entry at phase + 1
        RD_CUR  = 1'b1    // curve entry at phase
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADV,
        S_CHK,
        S_RD1,
        S_RD2,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_TGT,
        S_RUN,
        S_OUT
    } ctl_state_t;

    typedef struct packed {
        logic    capture;
        logic    do_start;
        logic    do_stop;
        logic    do_write;
        logic    sample_pre;
        rd_sel_t rd_sel;
        logic    advance;
        logic    latch_lo;
        logic    latch_hi;
        logic    curve_end;
        logic    mul;
        logic    div_start;
        logic    set_target;
        logic    finish_run;
        logic    out_load;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic gate;         // heating armed with positive target
        logic curve_en;
        logic curve_done;   // no point beyond the current phase
        logic div_done;
    } dp_status_t;

endpackage

[hdl/reflow_profile_heater_control.sv]
// Top level of the reflow profile heater controller (bang-bang, profile following).
// Depends on rphc_pkg, rphc_ctrl, rphc_datapath (which holds rphc_div).
//
//  channel   dir  handshake                    content
//  -------   ---  ---------------------------  -------------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  command beat: sample/start/stop/point
//  m_axis    out  m_axis_tvalid/m_axis_tready  status beat, one per command beat
//  cfg       in   cfg_we (no wait)             register write by index
//
// One beat is in flight at a time. Start, stop, point write and an idle
//   sample go straight to output; a sample without the curve adds the run step.
// A curve sample adds the phase advance and, unless the curve ends there, two memory
//   reads, the multiply and the 45-step shift-subtract divider of the interpolation.
// Reset clears all control state and loads the register defaults; the curve
//   table is not cleared and holds garbage until points are written.
// A stalled result sits in the output register; the next beat is accepted
//   only after it has been loaded there.
module reflow_profile_heater_control #(
    parameter int MAX_POINTS = rphc_pkg::MAX_POINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command beat
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], measured_temp[45:32], point_index[49:46],
    // point_time_ms[81:50], point_temp[94:82], zero pad [95]
    input  logic [rphc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [rphc_pkg::OP_W-1:0]        s_axis_tuser,
    // result beat
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // heater_on[0], heating_active[1], runaway_detected[2],
    // current_target[16:3], current_phase[20:17], zero pad [23:21]
    output logic [rphc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // register writes
    input  logic                             cfg_we,
    input  logic [rphc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rphc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rphc_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // sequencer: owns the handshakes and the output valid
    rphc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // registers, curve table, multiply and divide
    rphc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_kind   (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

endmodule

[hdl/rphc_div.sv]
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Standalone; instantiated by rphc_datapath.
module rphc_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  dvs_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DCNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/rphc_datapath.sv]
// Datapath: config and control registers, curve point memory, interpolation math.
// Depends on rphc_pkg and rphc_div.
module rphc_datapath #(
    parameter int MAX_POINTS = rphc_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rphc_pkg::IN_TDATA_W-1:0]   in_data,
    input  logic [rphc_pkg::OP_W-1:0]         in_kind,
    input  logic                              cfg_we,
    input  logic [rphc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rphc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  rphc_pkg::ctl_cmd_t                cmd,
    output rphc_pkg::dp_status_t              status,
    output logic [rphc_pkg::OUT_TDATA_W-1:0]  out_data
);

    import rphc_pkg::*;

    localparam int PHASE_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int WIDX_W  = PHASE_W + PIDX_W;
    localparam int PWID_W  = PHASE_W + PHASE_OUT_W;
    localparam int CMP_W   = TEMP_W + 2;
    localparam logic signed [PROD_W-1:0] SUM_MIN = PROD_W'(TEMP_MIN);
    localparam logic signed [PROD_W-1:0] SUM_MAX = PROD_W'(TEMP_MAX);

    typedef struct packed {
        logic [TIME_W-1:0]  t;
        logic [PTEMP_W-1:0] p;
    } curve_pt_t;

    // config
    logic [PTEMP_W-1:0] fixed_target_reg;
    logic               curve_en_reg;
    logic [TIME_W-1:0]  timeout_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [USED_W-1:0]  used_reg;

    // controller state
    logic                     heating_reg;
    logic                     runaway_reg;
    logic                     heater_reg;
    logic signed [TEMP_W-1:0] target_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [TIME_W-1:0]        start_reg;
    logic [TIME_W-1:0]        inband_reg;
    logic signed [TEMP_W-1:0] prev_reg;

    // captured beat
    op_t                      op_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [TEMP_W-1:0] meas_reg;
    logic [PIDX_W-1:0]        pidx_reg;
    logic [TIME_W-1:0]        ptime_reg;
    logic [PTEMP_W-1:0]       ptemp_reg;

    // curve memory and operands
    curve_pt_t                mem [MAX_POINTS];
    curve_pt_t                rd_data_reg;
    logic [PHASE_W-1:0]       rd_addr;
    logic [TIME_W-1:0]        t1_reg;
    logic [TIME_W-1:0]        t2_reg;
    logic [PTEMP_W-1:0]       p1_reg;
    logic [PTEMP_W-1:0]       p2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] den_reg;
    logic [QMAG_W-1:0]        out_q;
    logic                     div_done;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic [TIME_W-1:0]        runtime;
    logic [CNT_W-1:0]         used_ext;
    logic [CNT_W-1:0]         used_eff;
    logic [CNT_W-1:0]         next_ext;
    logic                     has_next;
    logic                     adv_ok;
    logic                     timed_out;
    logic [WIDX_W-1:0]        pidx_wide;
    logic                     wr_ok;
    logic [PWID_W-1:0]        phase_wide;

    logic signed [TEMP_W-1:0] dtemp;
    logic signed [DIFF_W-1:0] dtime;
    logic signed [DIFF_W-1:0] dden;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] num_abs;
    logic signed [DIFF_W-1:0] den_abs;
    logic                     q_neg;
    logic signed [PROD_W-1:0] q_pos;
    logic signed [PROD_W-1:0] q_sgn;
    logic signed [PROD_W-1:0] sum;
    logic signed [TEMP_W-1:0] interp;
    logic signed [TEMP_W-1:0] start_target;

    logic signed [CMP_W-1:0]  prev_ext;
    logic signed [CMP_W-1:0]  meas_ext;
    logic signed [CMP_W-1:0]  band_ext;
    logic                     inband;

    // --- phase bookkeeping ---
    assign runtime  = now_reg - start_reg;
    assign used_ext = CNT_W'(used_reg);
    assign used_eff = (used_ext > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : used_ext;
    assign next_ext = CNT_W'(phase_reg) + 1'b1;
    assign has_next = next_ext < used_eff;
    assign adv_ok   = has_next && (runtime >= rd_data_reg.t);
    assign rd_addr  = (cmd.rd_sel == RD_CUR) ? phase_reg : phase_reg + 1'b1;

    assign timed_out = (now_reg - inband_reg) >= timeout_reg;

    assign pidx_wide = WIDX_W'(pidx_reg);
    assign wr_ok     = pidx_wide < WIDX_W'(MAX_POINTS);

    // --- interpolation ---
    assign dtemp = $signed({1'b0, p2_reg}) - $signed({1'b0, p1_reg});
    assign dtime = $signed({1'b0, runtime}) - $signed({1'b0, t1_reg});
    assign dden  = $signed({1'b0, t2_reg}) - $signed({1'b0, t1_reg});
    assign prod  = PROD_W'(dtemp) * PROD_W'(dtime);

    assign num_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign den_abs = den_reg[DIFF_W-1] ? -den_reg : den_reg;
    assign q_neg   = prod_reg[PROD_W-1] ^ den_reg[DIFF_W-1];
    assign q_pos   = $signed({{(PROD_W-QMAG_W){1'b0}}, out_q});
    assign q_sgn   = q_neg ? -q_pos : q_pos;

    always_comb
    begin
        if (den_reg == '0)
            sum = $signed({{(PROD_W-PTEMP_W){1'b0}}, p2_reg});
        else
            sum = q_sgn + $signed({{(PROD_W-PTEMP_W){1'b0}}, p1_reg});
        if (sum < SUM_MIN)
            interp = TEMP_MIN;
        else if (sum > SUM_MAX)
            interp = TEMP_MAX;
        else
            interp = sum[TEMP_W-1:0];
    end

    assign start_target = (fixed_target_reg > FIXED_MAX) ? TEMP_MAX
                        : $signed({1'b0, fixed_target_reg});

    // band check: prev - band <= meas <= prev + band
    assign prev_ext = CMP_W'(prev_reg);
    assign meas_ext = CMP_W'(meas_reg);
    assign band_ext = $signed({{(CMP_W-BAND_W){1'b0}}, band_reg});
    assign inband   = (prev_ext - band_ext <= meas_ext) && (meas_ext <= prev_ext + band_ext);

    rphc_div #(
        .NUM_W (QMAG_W),
        .DEN_W (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_abs[QMAG_W-1:0]),
        .divisor  (den_abs[TIME_W-1:0]),
        .done     (div_done),
        .quotient (out_q)
    );

    // --- config registers ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_target_reg <= '0;
            curve_en_reg     <= 1'b0;
            timeout_reg      <= RESET_TIMEOUT;
            band_reg         <= RESET_BAND;
            used_reg         <= RESET_USED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIXED_TARGET: fixed_target_reg <= cfg_data[PTEMP_W-1:0];
                CFG_CURVE_ENABLE: curve_en_reg     <= cfg_data[0];
                CFG_TIMEOUT:      timeout_reg      <= cfg_data[TIME_W-1:0];
                CFG_BAND:         band_reg         <= cfg_data[BAND_W-1:0];
                CFG_POINTS_USED:  used_reg         <= cfg_data[USED_W-1:0];
                default:          ;
            endcase
        end
    end

    // --- control state ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heating_reg <= 1'b0;
            runaway_reg <= 1'b0;
            heater_reg  <= 1'b0;
            target_reg  <= '0;
            phase_reg   <= '0;
            start_reg   <= '0;
            inband_reg  <= '0;
            prev_reg    <= '0;
        end
        else
        begin
            if (cmd.capture)
                heater_reg <= 1'b0;
            if (cmd.do_start)
            begin
                heating_reg <= 1'b1;
                phase_reg   <= '0;
                start_reg   <= now_reg;
                inband_reg  <= now_reg;
                target_reg  <= start_target;
            end
            if (cmd.do_stop)
                heating_reg <= 1'b0;
            if (cmd.sample_pre && timed_out)
            begin
                heating_reg <= 1'b0;
                runaway_reg <= 1'b1;
            end
            if (cmd.advance && adv_ok)
                phase_reg <= phase_reg + 1'b1;
            if (cmd.curve_end)
            begin
                target_reg  <= '0;
                heating_reg <= 1'b0;
            end
            if (cmd.set_target)
                target_reg <= interp;
            if (cmd.finish_run)
            begin
                heater_reg <= heating_reg && (meas_reg < target_reg);
                prev_reg   <= meas_reg;
                if (inband)
                    inband_reg <= now_reg;
            end
        end
    end

    // --- beat capture, operands, memory ---
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(in_kind);
            now_reg   <= in_data[31:0];
            meas_reg  <= in_data[45:32];
            pidx_reg  <= in_data[49:46];
            ptime_reg <= in_data[81:50];
            ptemp_reg <= in_data[94:82];
        end
        if (cmd.latch_lo)
        begin
            t1_reg <= rd_data_reg.t;
            p1_reg <= rd_data_reg.p;
        end
        if (cmd.latch_hi)
        begin
            t2_reg <= rd_data_reg.t;
            p2_reg <= rd_data_reg.p;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod;
            den_reg  <= dden;
        end
        if (cmd.out_load)
            out_data_reg <= {3'b000, phase_wide[PHASE_OUT_W-1:0], target_reg,
                             runaway_reg, heating_reg, heater_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && wr_ok)
            mem[pidx_wide[PHASE_W-1:0]] <= {ptime_reg, ptemp_reg};
        rd_data_reg <= mem[rd_addr];
    end

    assign phase_wide = PWID_W'(phase_reg);

    assign status.op         = op_reg;
    assign status.gate       = heating_reg && (target_reg > 14'sd0);
    assign status.curve_en   = curve_en_reg;
    assign status.curve_done = !has_next;
    assign status.div_done   = div_done;

    assign out_data = out_data_reg;

    a_runaway_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        runaway_reg |=> runaway_reg)
        else $error("runaway flag cleared without reset");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        (target_reg >= TEMP_MIN) && (target_reg <= TEMP_MAX))
        else $error("target outside temperature range");

    a_heater_needs_heating: assert property (@(posedge clk) disable iff (!rst_n)
        heater_reg |-> heating_reg)
        else $error("heater on while heating disarmed");

    a_phase_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(phase_reg) < CNT_W'(MAX_POINTS))
        else $error("phase beyond curve table");

endmodule

[hdl/rphc_ctrl.sv]
// Sequencer for the heater controller: steps one beat through the datapath.
// Depends on rphc_pkg.
module rphc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rphc_pkg::dp_status_t status,
    output rphc_pkg::ctl_cmd_t   cmd
);

    import rphc_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_OUT;
                case (status.op)
                    OP_START: cmd.do_start = 1'b1;
                    OP_STOP:  cmd.do_stop  = 1'b1;
                    OP_WRITE: cmd.do_write = 1'b1;
                    OP_SAMPLE:
                    begin
                        if (status.gate)
                        begin
                            cmd.sample_pre = 1'b1;
                            if (status.curve_en)
                            begin
                                cmd.rd_sel = RD_NEXT;
                                state_next = S_ADV;
                            end
                            else
                                state_next = S_RUN;
                        end
                    end
                    default: ;
                endcase
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                if (status.curve_done)
                begin
                    cmd.curve_end = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.rd_sel = RD_CUR;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                cmd.latch_lo = 1'b1;
                cmd.rd_sel   = RD_NEXT;
                state_next   = S_RD2;
            end
            S_RD2:
            begin
                cmd.latch_hi = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.set_target = 1'b1;
                state_next     = S_RUN;
            end
            S_RUN:
            begin
                cmd.finish_run = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while one is in flight");

endmodule

[dv/heater_status_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the reflow heater controller: watches the command, status and
// register ports, predicts each status beat and compares. Depends on rphc_pkg.
module heater_status_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [rphc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [rphc_pkg::OP_W-1:0]         s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [rphc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [rphc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rphc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                pending
);

    import rphc_pkg::*;

    localparam int TABLE_DEPTH = MAX_POINTS_DEF;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic                     heater_on;
        logic                     heating_active;
        logic                     runaway;
        logic signed [TEMP_W-1:0] target;
        logic [PHASE_OUT_W-1:0]   phase;
    } heater_status_t;

    // register copies
    logic [PTEMP_W-1:0] fixed_target_r;
    logic               curve_en_r;
    logic [TIME_W-1:0]  timeout_r;
    logic [BAND_W-1:0]  band_r;
    logic [USED_W-1:0]  points_used_r;

    // controller state
    bit                 heat_armed;
    bit                 runaway_seen;
    int                 target_q;
    int unsigned        phase_q;
    logic [TIME_W-1:0]  start_ms;
    logic [TIME_W-1:0]  inband_ms;
    int                 prev_temp;
    logic [TIME_W-1:0]  pt_time [TABLE_DEPTH];
    logic [PTEMP_W-1:0] pt_temp [TABLE_DEPTH];

    heater_status_t status_due[$];
    int errors;
    int results_seen;

    function automatic int clamp_q(input longint v);
        if (v < longint'(TEMP_MIN))
            return int'(TEMP_MIN);
        if (v > longint'(TEMP_MAX))
            return int'(TEMP_MAX);
        return int'(v);
    endfunction

    // Steps the profile phase and interpolates; 0 when the curve has run out.
    function automatic bit track_profile(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] runtime;
        int unsigned       used;
        longint            t1;
        longint            t2;
        longint            p1;
        longint            p2;
        longint            interp;
        runtime = now - start_ms;
        used = (points_used_r > TABLE_DEPTH) ? TABLE_DEPTH : points_used_r;
        if (phase_q + 1 < used && runtime >= pt_time[phase_q + 1])
            phase_q++;
        if (phase_q + 1 >= used)
            return 1'b0;
        t1 = longint'(pt_time[phase_q]);
        t2 = longint'(pt_time[phase_q + 1]);
        p1 = longint'(pt_temp[phase_q]);
        p2 = longint'(pt_temp[phase_q + 1]);
        if (t2 == t1)
            interp = p2;
        else
            interp = p1 + ((p2 - p1) * (longint'(runtime) - t1)) / (t2 - t1);
        target_q = clamp_q(interp);
        return 1'b1;
    endfunction

    function automatic heater_status_t next_heater_status(
        input op_t                      op,
        input logic [TIME_W-1:0]        now,
        input logic signed [TEMP_W-1:0] meas,
        input logic [PIDX_W-1:0]        idx,
        input logic [TIME_W-1:0]        ptime,
        input logic [PTEMP_W-1:0]       ptemp
    );
        heater_status_t st;
        bit heater;
        bit running;
        int temp_v;
        int band;
        heater = 1'b0;
        temp_v = meas;
        case (op)
            OP_SAMPLE:
            begin
                if (target_q > 0 && heat_armed)
                begin
                    running = 1'b1;
                    if (now - inband_ms >= timeout_r)
                    begin
                        heat_armed   = 1'b0;
                        runaway_seen = 1'b1;
                    end
                    if (curve_en_r && !track_profile(now))
                    begin
                        target_q   = 0;
                        heat_armed = 1'b0;
                        running    = 1'b0;
                    end
                    if (running)
                    begin
                        band   = band_r;
                        heater = heat_armed && temp_v < target_q;
                        if (prev_temp - band <= temp_v && temp_v <= prev_temp + band)
                            inband_ms = now;
                        prev_temp = temp_v;
                    end
                end
            end
            OP_START:
            begin
                heat_armed = 1'b1;
                phase_q    = 0;
                start_ms   = now;
                inband_ms  = now;
                target_q   = (fixed_target_r > FIXED_MAX) ? FIXED_MAX : fixed_target_r;
            end
            OP_STOP:
                heat_armed = 1'b0;
            default:
            begin
                pt_time[idx] = ptime;
                pt_temp[idx] = ptemp;
            end
        endcase
        st.heater_on      = heater;
        st.heating_active = heat_armed;
        st.runaway        = runaway_seen;
        st.target         = TEMP_W'(target_q);
        st.phase          = PHASE_OUT_W'(phase_q);
        return st;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_FIXED_TARGET: fixed_target_r = value[PTEMP_W-1:0];
            CFG_CURVE_ENABLE: curve_en_r     = value[0];
            CFG_TIMEOUT:      timeout_r      = value[TIME_W-1:0];
            CFG_BAND:         band_r         = value[BAND_W-1:0];
            CFG_POINTS_USED:  points_used_r  = value[USED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("[%0t] status beat %0d, %s: got %0d, expected %0d",
                     $time, results_seen, what, got_v, want_v);
    endtask

    task automatic check_status(input logic [OUT_TDATA_W-1:0] beat);
        heater_status_t want;
        results_seen++;
        if (status_due.size() == 0)
        begin
            report_mismatch("beat with no command outstanding", 1, 0);
            return;
        end
        want = status_due.pop_front();
        if (beat[0] !== want.heater_on)
            report_mismatch("heater_on", beat[0], want.heater_on);
        if (beat[1] !== want.heating_active)
            report_mismatch("heating_active", beat[1], want.heating_active);
        if (beat[2] !== want.runaway)
            report_mismatch("runaway_detected", beat[2], want.runaway);
        if (beat[16:3] !== want.target)
            report_mismatch("current_target", $signed(beat[16:3]), want.target);
        if (beat[20:17] !== want.phase)
            report_mismatch("current_phase", beat[20:17], want.phase);
        if (beat[23:21] !== 3'b000)
            report_mismatch("pad bits", beat[23:21], 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_target_r = '0;
            curve_en_r     = 1'b0;
            timeout_r      = RESET_TIMEOUT;
            band_r         = RESET_BAND;
            points_used_r  = RESET_USED;
            heat_armed     = 1'b0;
            runaway_seen   = 1'b0;
            target_q       = 0;
            phase_q        = 0;
            start_ms       = '0;
            inband_ms      = '0;
            prev_temp      = 0;
            status_due.delete();
            errors         = 0;
            results_seen   = 0;
            fail_count    <= 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_we)
                write_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(next_heater_status(op_t'(s_axis_tuser),
                                                        s_axis_tdata[31:0],
                                                        $signed(s_axis_tdata[45:32]),
                                                        s_axis_tdata[49:46],
                                                        s_axis_tdata[81:50],
                                                        s_axis_tdata[94:82]));
            if (m_axis_tvalid && m_axis_tready)
                check_status(m_axis_tdata);
            fail_count <= errors;
            pending    <= status_due.size();
        end
    end

endmodule

[dv/reflow_profile_heater_control_tb.sv]
`timescale 1ns / 100ps
// Top of the reflow heater controller testbench: clock, reset, command and
// register stimulus, status back-pressure, watchdog and verdict. Depends on
// rphc_pkg, reflow_profile_heater_control and heater_status_checker.
module reflow_profile_heater_control_tb;

    import rphc_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int TOTAL_ITEMS    = 820;   // directed part plus about 800 random
    localparam int SETTLE_CYCLES  = 4;     // after the last status beat is back
    localparam int DRAIN_CYCLES   = 64;    // after the final settle, before the verdict
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int outstanding;

    // stimulus bookkeeping
    logic [TIME_W-1:0] clock_ms = 32'd10000;  // plate time as the sender sees it
    int                last_temp = 0;         // random walk of the measured temp
    int                items_sent = 0;
    bit                steady = 1'b0;         // phase with no gaps or stalls
    int                ready_hold = 0;
    int                quiet_cycles = 0;

    always #4 clk = ~clk;

    reflow_profile_heater_control u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    heater_status_checker u_status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (mismatches),
        .pending       (outstanding)
    );

    // Status back-pressure: ready and stall stretches of random length, most
    // short, a few long; held high through steady phases.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (steady)
            m_axis_tready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 99) < 65)
        begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 8);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
        end
    end

    // Watchdog: any beat on either side resets the quiet count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("reflow_profile_heater_control_tb failed");
            $finish;
        end
    end

    // One command beat. Valid stays up after the handshake so that a
    // back-to-back beat is never lowered and raised in the same step.
    task automatic send_beat(input op_t op, input logic [TIME_W-1:0] now, input int temp,
                             input logic [PIDX_W-1:0] idx, input logic [TIME_W-1:0] ptime,
                             input logic [PTEMP_W-1:0] ptemp);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        // tdata: now, measured temp, point index, point time, point temp, pad
        s_axis_tdata  <= {1'b0, ptemp, ptime, idx, TEMP_W'(temp), now};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Unused fields of each command carry random bits.
    task automatic sample_at(input logic [TIME_W-1:0] now, input int temp);
        send_beat(OP_SAMPLE, now, temp, PIDX_W'($urandom), $urandom,
                  PTEMP_W'($urandom_range(0, 8000)));
    endtask

    task automatic start_at(input logic [TIME_W-1:0] now);
        send_beat(OP_START, now, int'($urandom_range(0, 8800)) - 800, PIDX_W'($urandom),
                  $urandom, PTEMP_W'($urandom_range(0, 8000)));
    endtask

    task automatic stop_at(input logic [TIME_W-1:0] now);
        send_beat(OP_STOP, now, int'($urandom_range(0, 8800)) - 800, PIDX_W'($urandom),
                  $urandom, PTEMP_W'($urandom_range(0, 8000)));
    endtask

    task automatic put_point(input logic [PIDX_W-1:0] idx, input logic [TIME_W-1:0] t,
                             input logic [PTEMP_W-1:0] p);
        send_beat(OP_WRITE, $urandom, int'($urandom_range(0, 8800)) - 800, idx, t, p);
    endtask

    function automatic logic [PTEMP_W-1:0] profile_temp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return FIXED_MAX;
        return PTEMP_W'($urandom_range(0, 8000));
    endfunction

    // Hold off the sender until every status beat is back, then let the
    // block go quiet before anything else happens.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [PTEMP_W-1:0] fixed, input logic curve,
                                input logic [TIME_W-1:0] timeout,
                                input logic [BAND_W-1:0] band,
                                input logic [USED_W-1:0] used);
        write_reg(CFG_FIXED_TARGET, CFG_DATA_W'(fixed));
        write_reg(CFG_CURVE_ENABLE, CFG_DATA_W'(curve));
        write_reg(CFG_TIMEOUT,      timeout);
        write_reg(CFG_BAND,         CFG_DATA_W'(band));
        write_reg(CFG_POINTS_USED,  CFG_DATA_W'(used));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int                 phase_no;
        int                 n_pts;
        int                 n_samples;
        int                 r;
        int                 spread;
        bit                 sorted;
        logic [TIME_W-1:0]  t_acc;
        logic [PTEMP_W-1:0] fixed_cfg;
        logic               curve_cfg;
        logic [TIME_W-1:0]  timeout_cfg;
        logic [BAND_W-1:0]  band_cfg;
        logic [USED_W-1:0]  used_cfg;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // Fixed target above 8000 saturates; temps at both ends of the range.
        program_regs(13'd8191, 1'b0, RESET_TIMEOUT, RESET_BAND, RESET_USED);
        sample_at(32'd500, 100);        // not heating: heater stays off
        start_at(32'd1000);
        sample_at(32'd1010, -800);      // far below target: heater on
        sample_at(32'd1020, 8000);      // at target: off
        stop_at(32'd1030);
        sample_at(32'd1040, 0);

        // Zero target: samples leave everything alone.
        settle();
        program_regs(13'd0, 1'b0, RESET_TIMEOUT, RESET_BAND, RESET_USED);
        start_at(32'd2000);
        sample_at(32'd2010, 100);

        // Zero timeout: runaway on the first sample, heater off on that
        // step; a restart re-arms heating while the flag stays set.
        settle();
        program_regs(13'd500, 1'b0, 32'd0, 11'd0, RESET_USED);
        start_at(32'd3000);
        sample_at(32'd3000, 100);
        start_at(32'd3100);
        sample_at(32'd3101, 600);

        // Three point curve with equal times on the second segment, started
        // just before the millisecond clock wraps; the third sample ends it.
        settle();
        program_regs(13'd1, 1'b1, 32'hFFFF_FFFF, 11'd1600, 5'd3);
        put_point(4'd0, 32'd0, 13'd0);
        put_point(4'd1, 32'd100, 13'd8000);
        put_point(4'd2, 32'd100, 13'd4000);
        start_at(32'hFFFF_FFA0);
        sample_at(32'hFFFF_FFD2, 0);    // halfway up the first ramp
        sample_at(32'd4, 100);          // wrapped: runtime 100, flat step to p2
        sample_at(32'd104, 200);        // no point left beyond: curve done

        // Fewer than two points: the curve ends on its first step.
        settle();
        program_regs(13'd100, 1'b1, RESET_TIMEOUT, RESET_BAND, 5'd1);
        start_at(32'd5000);
        sample_at(32'd5010, 50);

        // ---- random: one register setting, profile and run per pass ----
        phase_no = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            settle();
            steady <= ($urandom_range(0, 3) == 0);

            r = $urandom_range(0, 99);
            if (r < 10)
                fixed_cfg = '0;
            else if (r < 20)
                fixed_cfg = PTEMP_W'($urandom_range(8001, 8191));
            else
                fixed_cfg = PTEMP_W'($urandom_range(1, 8000));

            curve_cfg = ($urandom_range(0, 9) < 7);

            r = $urandom_range(0, 99);
            if (r < 8)
                timeout_cfg = '0;
            else if (r < 16)
                timeout_cfg = '1;
            else if (r < 28)
                timeout_cfg = $urandom_range(1, 20);
            else
                timeout_cfg = $urandom_range(100, 4000);

            r = $urandom_range(0, 99);
            if (r < 10)
                band_cfg = '0;
            else if (r < 20)
                band_cfg = 11'd1600;
            else
                band_cfg = BAND_W'($urandom_range(0, 300));

            // first two passes: above the table size, then below two points
            r = $urandom_range(0, 99);
            if (phase_no == 0)
                used_cfg = 5'd31;
            else if (phase_no == 1)
                used_cfg = 5'd1;
            else if (r < 6)
                used_cfg = 5'd0;
            else if (r < 12)
                used_cfg = USED_W'($urandom_range(17, 31));
            else if (r < 18)
                used_cfg = 5'd16;
            else
                used_cfg = USED_W'($urandom_range(2, 16));

            program_regs(fixed_cfg, curve_cfg, timeout_cfg, band_cfg, used_cfg);

            // Every entry the curve can reach is loaded before the start.
            if (curve_cfg)
            begin
                n_pts = (used_cfg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : used_cfg;
                if (n_pts < 2)
                    n_pts = 2;
                sorted = ($urandom_range(0, 4) != 0);
                t_acc  = $urandom_range(0, 50);
                for (int i = 0; i < n_pts; i++)
                begin
                    put_point(PIDX_W'(i), sorted ? t_acc : TIME_W'($urandom_range(0, 3000)),
                              profile_temp());
                    t_acc += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
                end
            end

            if ($urandom_range(0, 19) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            last_temp = $urandom_range(0, 3000);
            start_at(clock_ms);

            n_samples = $urandom_range(10, 40);
            for (int s = 0; s < n_samples; s++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    stop_at(clock_ms);
                else if (r < 8)
                    start_at(clock_ms);
                else if (r < 12)
                    put_point(PIDX_W'($urandom_range(0, 15)), $urandom_range(0, 3000),
                              profile_temp());
                else if (r < 15)
                    // noise: any command with fully random content
                    send_beat(op_t'($urandom_range(0, 3)), $urandom,
                              int'($urandom_range(0, 8800)) - 800, PIDX_W'($urandom),
                              $urandom, PTEMP_W'($urandom_range(0, 8000)));
                else if (r < 17)
                    settle();
                else
                begin
                    // mostly small time steps, some long enough to trip runaway
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        clock_ms += $urandom_range(0, 150);
                    else if (r < 92)
                        clock_ms += $urandom_range(150, 600);
                    else
                        clock_ms += $urandom_range(600, 6000);
                    if ($urandom_range(0, 9) == 0)
                        last_temp = int'($urandom_range(0, 8800)) - 800;
                    else
                    begin
                        // walk mostly inside the runaway band
                        spread = band_cfg + 8;
                        last_temp += int'($urandom_range(0, 2 * spread)) - spread;
                        if (last_temp < -800)
                            last_temp = -800;
                        if (last_temp > 8000)
                            last_temp = 8000;
                    end
                    sample_at(clock_ms, last_temp);
                end
            end
            phase_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("reflow_profile_heater_control_tb passed");
        else
            $display("reflow_profile_heater_control_tb failed");
        $finish;
    end

endmodule
